// ----- sv/osa_ed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optimal string alignment distance - shared definitions
// Types, codes and arithmetic helpers used by the cell row and the top level.
// ----------------------------------------------------------------------------
package osa_ed_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int DIST_W      = 16;
    localparam int SYM_W       = 8;
    localparam int COST_W      = 8;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_STREAM = 2'd1,
        FUNC_END    = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INSERT     = 2'd0,
        CFG_DELETE     = 2'd1,
        CFG_SUBSTITUTE = 2'd2,
        CFG_TRANSPOSE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       func;
        logic [SYM_W-1:0] symbol;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              too_long;
    } t_out;

    typedef struct packed {
        logic [COST_W-1:0] ins;
        logic [COST_W-1:0] del;
        logic [COST_W-1:0] sub;
        logic [COST_W-1:0] trn;
    } t_costs;

    // Wavefront token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [SYM_W-1:0]  sym;        // current first-string symbol
        logic [SYM_W-1:0]  last_sym;   // previous first-string symbol
        logic              deep;       // at least one earlier first-string symbol
        logic              near_ok;    // left neighbour is a real column
        logic [SYM_W-1:0]  near_sym;   // second-string symbol of left neighbour
        logic [DIST_W-1:0] new_val;    // new row value of left neighbour
        logic [DIST_W-1:0] prev_val;   // old row value of left neighbour
        logic [DIST_W-1:0] prev2_near; // row before previous, left neighbour
        logic [DIST_W-1:0] prev2_far;  // row before previous, two to the left
    } t_token;

    // Load broadcast: writes one column of the row.
    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  sym;
        logic [DIST_W-1:0] margin;
    } t_load;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {{(DIST_W + 1 - COST_W){1'b0}}, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- sv/osa_ed_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optimal string alignment distance - column cell
// Holds one second-string symbol and its two stored row values, and updates
// them when the wavefront token passes.
// ----------------------------------------------------------------------------
module osa_ed_cell #(
    parameter int MAX_LEN  = osa_ed_pkg::MAX_LEN_DEF,
    parameter int CELL_IDX = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  osa_ed_pkg::t_costs               i_costs,
    input  osa_ed_pkg::t_load                i_load,
    input  logic [$clog2(MAX_LEN + 1)-1:0]   i_load_idx,
    input  osa_ed_pkg::t_token               i_tok,
    input  logic [$clog2(MAX_LEN + 1)-1:0]   i_remain,
    output osa_ed_pkg::t_token               o_tok,
    output logic [$clog2(MAX_LEN + 1)-1:0]   o_remain
);
    import osa_ed_pkg::*;

    localparam int RW = $clog2(MAX_LEN + 1);

    logic [SYM_W-1:0]  r_sym;
    logic [DIST_W-1:0] r_prev;
    logic [DIST_W-1:0] r_prev2;
    t_token            r_tok;
    t_token            n_tok;
    logic [RW-1:0]     r_remain;
    logic [RW-1:0]     n_remain;

    logic              active;
    logic              differ;
    logic              transpose_ok;
    logic [DIST_W-1:0] best;

    // The cell takes part only while the token still has columns to visit.
    assign active = i_tok.valid && (i_remain != '0);
    assign differ = (i_tok.sym != r_sym);
    assign transpose_ok = i_tok.deep && i_tok.near_ok &&
                          (i_tok.sym == i_tok.near_sym) && (i_tok.last_sym == r_sym);

    always_comb begin
        best = sat_add(r_prev, i_costs.ins);
        best = min2(best, sat_add(i_tok.new_val, i_costs.del));
        best = min2(best, sat_add(i_tok.prev_val, differ ? i_costs.sub : '0));
        if (transpose_ok) begin
            best = min2(best, sat_add(i_tok.prev2_far, differ ? i_costs.trn : '0));
        end
    end

    always_comb begin
        n_tok    = i_tok;
        n_remain = (i_remain == '0) ? '0 : i_remain - RW'(1);
        if (active) begin
            n_tok.near_ok    = 1'b1;
            n_tok.near_sym   = r_sym;
            n_tok.new_val    = best;
            n_tok.prev_val   = r_prev;
            n_tok.prev2_near = r_prev2;
            n_tok.prev2_far  = i_tok.prev2_near;
        end
    end

    // Only the valid bit is reset; the rest of the token is qualified by it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.sym        <= n_tok.sym;
        r_tok.last_sym   <= n_tok.last_sym;
        r_tok.deep       <= n_tok.deep;
        r_tok.near_ok    <= n_tok.near_ok;
        r_tok.near_sym   <= n_tok.near_sym;
        r_tok.new_val    <= n_tok.new_val;
        r_tok.prev_val   <= n_tok.prev_val;
        r_tok.prev2_near <= n_tok.prev2_near;
        r_tok.prev2_far  <= n_tok.prev2_far;
        r_remain         <= n_remain;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.en && (i_load_idx == RW'(CELL_IDX - 1))) begin
            r_sym  <= i_load.sym;
            r_prev <= i_load.margin;
        end else if (active) begin
            r_prev  <= best;
            r_prev2 <= r_prev;
        end
    end

    assign o_tok    = r_tok;
    assign o_remain = r_remain;

endmodule

// ----- sv/osa_edit_distance_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optimal string alignment distance - top level
// Weighted edit distance with adjacent transposition over a row of cells.
// ----------------------------------------------------------------------------
// Usage. Input transactions carry a function code and a symbol. A load
// transaction appends a symbol to the second string. A stream transaction
// computes one new row of the alignment matrix: a token leaves the top level
// and walks the row of MAX_LEN cells, one cell per cycle, and the block is
// busy and stalls its input until the token has left the last cell. The walk
// length is set by the cell row, whose final value is captured at its far
// end. An end transaction places the distance and the overflow flag in the
// output register, from which it is offered in the following cycle; the pair
// is then cleared.
// Loads beyond MAX_LEN symbols are dropped and flag the result as too long.
// Loads after streaming has begun and the unused function code are ignored.
// The output register holds a result while the receiver stalls; load and
// stream transactions are still taken then, and an end transaction waits
// until the register is free or is being emptied in the same cycle.
// Reset clears the pair and sets all four costs to one. Configuration
// writes take effect at once and are intended for idle periods only.
// ----------------------------------------------------------------------------
module osa_edit_distance_top #(
    parameter int MAX_LEN = osa_ed_pkg::MAX_LEN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  osa_ed_pkg::t_in                      i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output osa_ed_pkg::t_out                     o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [osa_ed_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [osa_ed_pkg::COST_W-1:0]        i_cfg_data
);
    import osa_ed_pkg::*;

    localparam int RW = $clog2(MAX_LEN + 1);

    // Configuration registers.
    t_costs r_costs;

    // Pair state held at the top level: column zero of the two stored rows,
    // the stored value of the last real column, and the pair bookkeeping.
    logic [DIST_W-1:0] r_row0;
    logic [DIST_W-1:0] r_row0_2;
    logic [DIST_W-1:0] r_tail;
    logic [SYM_W-1:0]  r_last;
    logic              r_started;
    logic [RW-1:0]     r_len;
    logic              r_ovf;
    logic              r_busy;

    // Token launched into the first cell.
    t_token            r_tok0;
    logic [RW-1:0]     r_remain0;

    // Load broadcast towards the cells.
    t_load             r_load;
    logic [RW-1:0]     r_load_idx;

    // Output register.
    logic              r_out_valid;
    t_out              r_out;

    t_token            tok    [MAX_LEN + 1];
    logic [RW-1:0]     remain [MAX_LEN + 1];

    logic              accept;
    logic              can_end;
    logic [DIST_W-1:0] row0_new;
    logic [DIST_W-1:0] margin_new;
    logic              len_full;

    assign can_end    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || ((i_in_data.func == FUNC_END) && !can_end);
    assign accept     = i_in_valid && !o_in_stall;
    assign row0_new   = sat_add(r_row0, r_costs.ins);
    assign margin_new = sat_add(r_tail, r_costs.del);
    assign len_full   = (r_len == RW'(MAX_LEN));

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_costs <= '{ins: COST_W'(1), del: COST_W'(1), sub: COST_W'(1),
                         trn: COST_W'(1)};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INSERT:     r_costs.ins <= i_cfg_data;
                CFG_DELETE:     r_costs.del <= i_cfg_data;
                CFG_SUBSTITUTE: r_costs.sub <= i_cfg_data;
                CFG_TRANSPOSE:  r_costs.trn <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Transaction decoding and pair control. The payload registers are not
    // reset; they are qualified by the valid and enable bits beside them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0      <= '0;
            r_tail      <= '0;
            r_last      <= '0;
            r_started   <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_busy      <= 1'b0;
            r_tok0.valid <= 1'b0;
            r_load.en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tok0.valid <= 1'b0;
            r_load.en    <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // The token has left the last cell: its value is the new tail.
            if (tok[MAX_LEN].valid) begin
                r_tail <= tok[MAX_LEN].new_val;
                r_busy <= 1'b0;
            end
            if (accept) begin
                unique case (i_in_data.func)
                    FUNC_LOAD: begin
                        r_load.sym    <= i_in_data.symbol;
                        r_load.margin <= margin_new;
                        r_load_idx    <= r_len;
                        if (!r_started) begin
                            if (len_full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_load.en <= 1'b1;
                                r_tail    <= margin_new;
                                r_len     <= r_len + RW'(1);
                            end
                        end
                    end
                    FUNC_STREAM: begin
                        r_tok0.valid      <= 1'b1;
                        r_busy            <= 1'b1;
                        r_row0            <= row0_new;
                        r_last            <= i_in_data.symbol;
                        r_started         <= 1'b1;
                        r_row0_2          <= r_row0;
                        r_tok0.sym        <= i_in_data.symbol;
                        r_tok0.last_sym   <= r_last;
                        r_tok0.deep       <= r_started;
                        r_tok0.near_ok    <= 1'b0;
                        r_tok0.near_sym   <= '0;
                        r_tok0.new_val    <= row0_new;
                        r_tok0.prev_val   <= r_row0;
                        r_tok0.prev2_near <= r_row0_2;
                        r_tok0.prev2_far  <= '0;
                        r_remain0         <= r_len;
                    end
                    FUNC_END: begin
                        r_out_valid    <= 1'b1;
                        r_out.distance <= r_tail;
                        r_out.too_long <= r_ovf;
                        r_row0         <= '0;
                        r_tail         <= '0;
                        r_last         <= '0;
                        r_started      <= 1'b0;
                        r_len          <= '0;
                        r_ovf          <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign tok[0]    = r_tok0;
    assign remain[0] = r_remain0;

    // The row of column cells; the token moves one cell to the right per cycle.
    for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
        osa_ed_cell #(
            .MAX_LEN  (MAX_LEN),
            .CELL_IDX (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_costs    (r_costs),
            .i_load     (r_load),
            .i_load_idx (r_load_idx),
            .i_tok      (tok[j-1]),
            .i_remain   (remain[j-1]),
            .o_tok      (tok[j]),
            .o_remain   (remain[j])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
